FILE: src/msd_pkg.sv
// Shared constants and helpers for the Menger sponge distance pipeline.
// No dependencies.
package msd_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned FRAC_W  = 24;
  localparam int unsigned FOLD_W  = 25;           // p*s modulo 2 keeps 25 bits
  localparam int unsigned EXC_W   = 31;           // |p| - 1 clamped at 0
  localparam int unsigned SUM_W   = 64;           // sum of three squares
  localparam int unsigned ROOT_W  = 32;           // one root bit per stage
  localparam int unsigned TERM_W  = 26;           // signed level term
  localparam int unsigned BOX_LAT = 3;
  localparam int unsigned LVL_LAT = 5;

  localparam logic [COORD_W-1:0] ONE_Q = COORD_W'(1) << FRAC_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic signed [TERM_W-1:0] term_t;

  // 3^n modulo 2^40, elaboration only
  function automatic longint unsigned pow3(input int unsigned n);
    longint unsigned acc;
    acc = 64'd1;
    for (int unsigned i = 0; i < n; i++) begin
      acc = (acc * 64'd3) & 64'hFF_FFFF_FFFF;
    end
    return acc;
  endfunction

endpackage

FILE: src/menger_sponge_distance.sv
// Menger sponge distance estimator, top level.
// Depends on msd_pkg, msd_box, msd_isqrt, msd_level.
//
//   channel | beat content       | handshake
//   --------+--------------------+---------------------------
//   input   | px_i, py_i, pz_i   | in_valid_i / in_ready_o
//   output  | dist_res_o         | out_valid_o / out_ready_i
//
// One point per cycle while the output is not stalled; 3 box stages, 32 root stages,
// one output register. The square root pipeline sets the latency.
// All stages advance together; a stalled output holds the whole pipe.
// Reset clears the valid bits only.
module menger_sponge_distance #(
  parameter int unsigned LEVELS = 5
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [31:0]   px_i,
  input  logic signed [31:0]   py_i,
  input  logic signed [31:0]   pz_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [31:0]   dist_res_o
);

  localparam int unsigned PIPE_LAT = msd_pkg::BOX_LAT + msd_pkg::ROOT_W + 1;
  localparam int unsigned DLY      = msd_pkg::BOX_LAT + msd_pkg::ROOT_W
                                     - msd_pkg::LVL_LAT - 1;

  logic                          en;
  logic [PIPE_LAT-1:0]           vld_q;
  logic [msd_pkg::SUM_W-1:0]     sum;
  logic [msd_pkg::ROOT_W-1:0]    root;
  msd_pkg::term_t                terms [LEVELS];
  msd_pkg::term_t                tmax_d, tmax_q;
  msd_pkg::term_t                dly_q [DLY];
  logic signed [31:0]            res_d, res_q;

  assign en         = !vld_q[PIPE_LAT-1] || out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  msd_box u_box (
    .clk_i (clk_i),
    .en_i  (en),
    .px_i  (px_i),
    .py_i  (py_i),
    .pz_i  (pz_i),
    .sum_o (sum)
  );

  msd_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (sum),
    .root_o (root)
  );

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    msd_level #(.K(k)) u_level (
      .clk_i  (clk_i),
      .en_i   (en),
      .px_i   (px_i),
      .py_i   (py_i),
      .pz_i   (pz_i),
      .term_o (terms[k])
    );
  end

  always_comb begin
    tmax_d = terms[0];
    for (int k = 1; k < LEVELS; k++) begin
      if (terms[k] > tmax_d) begin
        tmax_d = terms[k];
      end
    end
  end

  // root is never negative, so the max only saturates on the high side
  always_comb begin
    logic signed [msd_pkg::ROOT_W+1:0] r_s, t_s, m_s;
    r_s = $signed({2'b00, root});
    t_s = (msd_pkg::ROOT_W+2)'(dly_q[DLY-1]);
    m_s = (t_s > r_s) ? t_s : r_s;
    res_d = (m_s > (msd_pkg::ROOT_W+2)'(32'sh7FFF_FFFF)) ? 32'sh7FFF_FFFF : 32'(m_s);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tmax_q <= tmax_d;
      dly_q[0] <= tmax_q;
      for (int i = 1; i < DLY; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
      res_q <= res_d;
    end
  end

  assign out_valid_o = vld_q[PIPE_LAT-1];
  assign dist_res_o  = res_q;

  a_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !dist_res_o[31])
    else $error("negative distance");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while output stalled");

  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> vld_q[0])
    else $error("accepted beat lost at pipe entry");

endmodule

FILE: src/msd_box.sv
// Box distance front end: |p| - 1 clamped, squared, summed (three stages).
// Depends on msd_pkg.
module msd_box (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  msd_pkg::coord_t               px_i,
  input  msd_pkg::coord_t               py_i,
  input  msd_pkg::coord_t               pz_i,
  output logic [msd_pkg::SUM_W-1:0]     sum_o
);

  logic [msd_pkg::EXC_W-1:0]   ex_d [3];
  logic [msd_pkg::EXC_W-1:0]   ex_q [3];
  logic [2*msd_pkg::EXC_W-1:0] sq_q [3];
  logic [msd_pkg::SUM_W-1:0]   sum_q;
  msd_pkg::coord_t             crd [3];

  assign crd[0] = px_i;
  assign crd[1] = py_i;
  assign crd[2] = pz_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [msd_pkg::COORD_W-1:0] mag;
      mag = crd[i][msd_pkg::COORD_W-1] ? (~crd[i] + 1'b1) : crd[i];
      ex_d[i] = (mag > msd_pkg::ONE_Q) ?
                msd_pkg::EXC_W'(mag - msd_pkg::ONE_Q) : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        ex_q[i] <= ex_d[i];
        sq_q[i] <= ex_q[i] * ex_q[i];
      end
      sum_q <= msd_pkg::SUM_W'(sq_q[0]) + msd_pkg::SUM_W'(sq_q[1])
             + msd_pkg::SUM_W'(sq_q[2]);
    end
  end

  assign sum_o = sum_q;

endmodule

FILE: src/msd_isqrt.sv
// Pipelined floor square root, one root bit per stage.
// Depends on msd_pkg.
module msd_isqrt (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [msd_pkg::SUM_W-1:0]     rad_i,
  output logic [msd_pkg::ROOT_W-1:0]    root_o
);

  localparam int unsigned N     = msd_pkg::ROOT_W;
  localparam int unsigned REM_W = N + 4;

  logic [REM_W-1:0]          rem_q  [N];
  logic [N-1:0]              root_q [N];
  logic [msd_pkg::SUM_W-1:0] rad_q  [N];

  for (genvar g = 0; g < N; g++) begin : g_stage
    logic [REM_W-1:0]          rem_in, rem_sh, trial;
    logic [N-1:0]              root_in;
    logic [msd_pkg::SUM_W-1:0] rad_in;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    // bring down the next two radicand bits
    assign rem_sh = {rem_in[REM_W-3:0], rad_in[msd_pkg::SUM_W-1 -: 2]};
    assign trial  = {2'b00, root_in, 2'b01};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[g] <= rad_in << 2;
        if (rem_sh >= trial) begin
          rem_q[g]  <= rem_sh - trial;
          root_q[g] <= {root_in[N-2:0], 1'b1};
        end else begin
          rem_q[g]  <= rem_sh;
          root_q[g] <= {root_in[N-2:0], 1'b0};
        end
      end
    end
  end

  assign root_o = root_q[N-1];

endmodule

FILE: src/msd_level.sv
// One sponge level: fold, cross term, exact divide by 3^(k+1) (five stages).
// Depends on msd_pkg.
module msd_level #(
  parameter int unsigned K = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  msd_pkg::coord_t px_i,
  input  msd_pkg::coord_t py_i,
  input  msd_pkg::coord_t pz_i,
  output msd_pkg::term_t  term_o
);

  localparam int unsigned FW = msd_pkg::FOLD_W;
  localparam longint unsigned SCALE = msd_pkg::pow3(K) & ((64'd1 << FW) - 1);
  localparam longint unsigned D     = msd_pkg::pow3(K + 1);
  // reciprocal exact for numerators below 2^FW
  localparam int unsigned     SH    = FW + $clog2(D);
  localparam longint unsigned M     = ((64'd1 << SH) + D - 1) / D;
  localparam int unsigned     MW    = FW + 1;

  localparam logic [FW-1:0] ONE_F = FW'(1) << msd_pkg::FRAC_W;

  msd_pkg::coord_t crd [3];
  logic [FW-1:0]   fold_q [3];
  logic [FW:0]     r_q    [3];
  logic [FW-1:0]   num_q;
  logic            neg_q, neg2_q;
  logic [FW+MW-1:0] prod_q;
  msd_pkg::term_t  term_q;
  logic [FW:0]     r_d [3];
  logic [FW:0]     mn_d;
  logic [FW-1:0]   quo;

  assign crd[0] = px_i;
  assign crd[1] = py_i;
  assign crd[2] = pz_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [FW-1:0] aa;
      logic [FW+1:0] t3;
      aa = (fold_q[i] >= ONE_F) ? (fold_q[i] - ONE_F) : (ONE_F - fold_q[i]);
      t3 = (FW+2)'(aa) + ((FW+2)'(aa) << 1);
      r_d[i] = (t3 >= (FW+2)'(ONE_F)) ? (FW+1)'(t3 - (FW+2)'(ONE_F))
                                      : (FW+1)'((FW+2)'(ONE_F) - t3);
    end
  end

  function automatic logic [FW:0] mx(input logic [FW:0] a, input logic [FW:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [FW:0] mi(input logic [FW:0] a, input logic [FW:0] b);
    return (a < b) ? a : b;
  endfunction

  assign mn_d = mi(mx(r_q[0], r_q[1]), mi(mx(r_q[1], r_q[2]), mx(r_q[2], r_q[0])));
  assign quo  = FW'(prod_q >> SH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        fold_q[i] <= FW'(crd[i][FW-1:0] * FW'(SCALE));
        r_q[i]    <= r_d[i];
      end
      neg_q  <= mn_d < (FW+1)'(ONE_F);
      num_q  <= (mn_d < (FW+1)'(ONE_F)) ? FW'((FW+1)'(ONE_F) - mn_d)
                                        : FW'(mn_d - (FW+1)'(ONE_F));
      neg2_q <= neg_q;
      prod_q <= num_q * MW'(M);
      term_q <= neg2_q ? -msd_pkg::term_t'(quo) : msd_pkg::term_t'(quo);
    end
  end

  assign term_o = term_q;

endmodule

FILE: bench/testbench.sv
// Self-checking bench for menger_sponge_distance: drives points over valid/ready,
// predicts each distance estimate in-bench and compares in order. Needs msd_pkg and the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVELS = 5;
  localparam int unsigned LAT    = 36;
  localparam logic signed [31:0] Q1   = 32'sh0100_0000;
  localparam logic signed [31:0] SMAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SMIN = 32'sh8000_0000;
  localparam logic signed [31:0] NOEXP = 32'sh1234_5679;  // row marker: use predictor

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] px_i = '0, py_i = '0, pz_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] dist_res_o;

  menger_sponge_distance #(.LEVELS(LEVELS)) DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  logic signed [31:0] dist_q[$];
  int errors = 0;
  idle_mode_e mode = IDLE_NONE;
  bit hold_off = 0;
  bit stim_done = 0;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned excess(logic signed [31:0] c);
    longint m;
    m = c;
    if (m < 0) m = -m;
    m -= longint'(Q1);
    return m > 0 ? longint'(m) : 0;
  endfunction

  function automatic longint fold_dev(logic [31:0] raw, longint unsigned scale);
    longint a, r;
    a = longint'((longint'(raw) * scale) & 64'h1FF_FFFF) - longint'(Q1);
    if (a < 0) a = -a;
    r = longint'(Q1) - 3 * a;
    return r < 0 ? -r : r;
  endfunction

  function automatic longint maxl(longint a, longint b);
    return a > b ? a : b;
  endfunction

  function automatic logic signed [31:0] sponge_dist(logic signed [31:0] x,
                                                     logic signed [31:0] y,
                                                     logic signed [31:0] z);
    longint unsigned ex, ey, ez, scale, dv;
    longint d, rx, ry, rz, m, c;
    ex = excess(x); ey = excess(y); ez = excess(z);
    d = longint'(root64(ex * ex + ey * ey + ez * ez));
    scale = 1;
    dv = 1;
    for (int k = 0; k < LEVELS; k++) begin
      rx = fold_dev(x, scale);
      ry = fold_dev(y, scale);
      rz = fold_dev(z, scale);
      m = maxl(rx, ry);
      if (maxl(ry, rz) < m) m = maxl(ry, rz);
      if (maxl(rz, rx) < m) m = maxl(rz, rx);
      scale = (scale * 3) & 64'h1FF_FFFF;
      if (dv < (64'd1 << 40)) dv *= 3;
      c = (m - longint'(Q1)) / longint'(dv);
      d = maxl(d, c);
    end
    if (d > longint'(SMAX)) d = SMAX;
    return d[31:0];
  endfunction

  // beat send: valid held until accepted, dropped only for idle cycles
  task automatic send_point(logic signed [31:0] x, y, z, logic signed [31:0] want);
    int unsigned idle_pct;
    idle_pct = (mode == IDLE_SEND) ? 87 : (mode == IDLE_BOTH) ? 6 : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    px_i <= x; py_i <= y; pz_i <= z;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    dist_q.push_back(want == NOEXP ? sponge_dist(x, y, z) : want);
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    if (hold_off) out_ready_i <= 1'b0;
    else if (mode == IDLE_RECV) out_ready_i <= ($urandom_range(99) >= 87);
    else if (mode == IDLE_BOTH) out_ready_i <= ($urandom_range(99) >= 6);
    else out_ready_i <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (dist_q.size() == 0) begin
        $display("%0t: unexpected result expected none actual %0d", $realtime, dist_res_o);
        errors++;
      end else begin
        if (dist_res_o !== dist_q[0]) begin
          $display("%0t: dist mismatch expected %0d actual %0d",
                   $realtime, dist_q[0], dist_res_o);
          errors++;
        end
        void'(dist_q.pop_front());
      end
    end
  end

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;  // in [-2,2]
      2: return $signed($urandom_range(32'h0600_0000)) - 32'sh0300_0000;
      3: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom())};
      4: return $urandom_range(1) ? SMAX - $urandom_range(3) : SMIN + $urandom_range(3);
      default: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
    endcase
  endfunction

  typedef struct {
    logic signed [31:0] x, y, z, want;
  } point_row_t;

  // expected typed in where it is obvious: far corners saturate; other rows use the predictor
  point_row_t rows[] = '{
    '{SMAX, SMAX, SMAX, SMAX},
    '{SMIN, SMIN, SMIN, SMAX},
    '{SMIN, 0, 0, NOEXP},
    '{SMAX, 0, 0, NOEXP},
    '{0, 0, 0, NOEXP},
    '{Q1, Q1, Q1, NOEXP},
    '{-Q1, -Q1, -Q1, NOEXP},
    '{Q1 + 1, 0, 0, NOEXP},
    '{-Q1 - 1, 0, 0, NOEXP},
    '{32'sh0080_0000, 32'sh0080_0000, 32'sh0080_0000, NOEXP},
    '{32'sh0055_5555, 32'sh0055_5556, 0, NOEXP},
    '{-1, -1, -1, NOEXP},
    '{1, 1, 1, NOEXP},
    '{32'sh0200_0000, 32'sh0200_0000, 32'sh0200_0000, NOEXP},
    '{32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F, NOEXP},
    '{32'shAAAA_AAAA, 32'sh5555_5555, 32'shF0F0_F0F0, NOEXP},
    '{0, SMIN, SMAX, NOEXP},
    '{32'sh00FF_FFFF, 32'sh0000_0001, 32'shFF00_0001, NOEXP}
  };

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].want);
    for (int ph = 0; ph < 8; ph++) begin
      mode = idle_mode_e'(ph % 4);
      for (int n = 0; n < 190; n++) send_point(rand_coord(), rand_coord(), rand_coord(), NOEXP);
    end
    in_valid_i <= 1'b0;
    stim_done = 1;
  end

  // long receiver stall while the sender keeps offering beats
  initial begin
    wait (rst_ni);
    repeat (60) @(negedge clk_i);
    hold_off = 1;
    repeat (150) @(negedge clk_i);
    hold_off = 0;
  end

  initial begin
    wait (stim_done);
    mode = IDLE_NONE;
    while (dist_q.size() != 0) @(posedge clk_i);
    repeat (2 * LAT) @(posedge clk_i);
    if (errors == 0) $display("menger_sponge_distance verification clean");
    else $display("menger_sponge_distance verification failed");
    $finish;
  end

  initial begin
    #4ms;
    $display("menger_sponge_distance verification failed");
    $finish;
  end
endmodule

FILE: filelist.f
src/msd_pkg.sv
src/msd_box.sv
src/msd_isqrt.sv
src/msd_level.sv
src/menger_sponge_distance.sv
bench/testbench.sv
